[hw/rtl/i2cts_pkg.sv]
// Shared constants and types for the I2C transfer sequencer.
// No dependencies; imported by the top level, the checker and the testbench.
`default_nettype none

package i2cts_pkg;

	localparam int BUF_BYTES = 32;
	localparam int BUF_AW    = $clog2(BUF_BYTES);
	localparam int LEN_W     = 6;
	localparam int CMD_W     = 5;

	localparam logic [LEN_W-1:0] BUF_LIMIT = LEN_W'(BUF_BYTES);

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_ACK     = 3'd1,
		ACT_NACK    = 3'd2,
		ACT_STOP    = 3'd3,
		ACT_RELEASE = 3'd4,
		ACT_START   = 3'd5
	} act_t;

	typedef enum logic [1:0] {
		MODE_READY = 2'd0,
		MODE_MTX   = 2'd1,
		MODE_SRX   = 2'd2,
		MODE_STX   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_ADDR_NACK = 3'd1,
		ERR_DATA_NACK = 3'd2,
		ERR_ARB_LOST  = 3'd3,
		ERR_RECV_FULL = 3'd4,
		ERR_BUS       = 3'd5
	} err_t;

	typedef enum logic [1:0] {
		SRC_CONST  = 2'd0,
		SRC_MASTER = 2'd1,
		SRC_REPLY  = 2'd2,
		SRC_RECV   = 2'd3
	} src_t;

	localparam logic [CMD_W-1:0] CMD_START_SENT  = 5'd0;
	localparam logic [CMD_W-1:0] CMD_MT_ACK      = 5'd1;
	localparam logic [CMD_W-1:0] CMD_MT_ADDR_NAK = 5'd2;
	localparam logic [CMD_W-1:0] CMD_MT_DATA_NAK = 5'd3;
	localparam logic [CMD_W-1:0] CMD_ARB_LOST    = 5'd4;
	localparam logic [CMD_W-1:0] CMD_MR_DATA_ACK = 5'd5;
	localparam logic [CMD_W-1:0] CMD_MR_ADDR_ACK = 5'd6;
	localparam logic [CMD_W-1:0] CMD_MR_DATA_NAK = 5'd7;
	localparam logic [CMD_W-1:0] CMD_MR_ADDR_NAK = 5'd8;
	localparam logic [CMD_W-1:0] CMD_SR_ADDRESSED = 5'd9;
	localparam logic [CMD_W-1:0] CMD_SR_DATA_ACK = 5'd10;
	localparam logic [CMD_W-1:0] CMD_SR_STOP     = 5'd11;
	localparam logic [CMD_W-1:0] CMD_SR_DATA_NAK = 5'd12;
	localparam logic [CMD_W-1:0] CMD_ST_ADDRESSED = 5'd13;
	localparam logic [CMD_W-1:0] CMD_ST_DATA_ACK = 5'd14;
	localparam logic [CMD_W-1:0] CMD_ST_DONE     = 5'd15;
	localparam logic [CMD_W-1:0] CMD_BUS_ERROR   = 5'd16;
	localparam logic [CMD_W-1:0] CMD_STOP_DONE   = 5'd17;
	localparam logic [CMD_W-1:0] CMD_BEGIN       = 5'd18;
	localparam logic [CMD_W-1:0] CMD_LOAD_MASTER = 5'd19;
	localparam logic [CMD_W-1:0] CMD_LOAD_REPLY  = 5'd20;
	localparam logic [CMD_W-1:0] CMD_READ        = 5'd21;
	localparam logic [CMD_W-1:0] CMD_TAKE_FRAME  = 5'd22;

endpackage

`default_nettype wire

[hw/rtl/i2c_master_slave_transfer_sequencer.sv]
// Top level of the I2C master/slave transfer sequencer.
// Depends on i2cts_pkg and i2cts_ram.
//
// Usage:
//  Input channel (in_valid/in_stall) carries one word per bus status event
//  or host access: cmd, data_byte, index, length, target_address,
//  read_not_write. Output channel (out_valid/out_stall) returns exactly one
//  result word per input word, in order.
//  Master, slave-receive and slave-reply buffers live in three RAMs with a
//  registered read; scalar state is in flops.
//  Path: an accepted word is held in the read stage, then in the output
//  register, which drives the outputs.
//  Throughput: one word per cycle while the output is not stalled. Each word does at most one read and one
//  write per buffer RAM at its accept edge, so the next word always sees it.
//  Stall: when out_stall holds, the output register holds its word, the
//  read stage fills, and then in_stall rises until the output drains.
//  Reset (arst_n low): mode ready, positions, lengths and error cleared,
//  no words in flight. Buffer contents are undefined until written.
`default_nettype none

module i2c_master_slave_transfer_sequencer
	import i2cts_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_stall,
	input  wire logic [4:0] cmd,
	input  wire logic [7:0] data_byte,
	input  wire logic [4:0] index,
	input  wire logic [5:0] length,
	input  wire logic [6:0] target_address,
	input  wire logic       read_not_write,
	output      logic       out_valid,
	input  wire logic       out_stall,
	output      logic [7:0] drive_byte,
	output      logic       drive_valid,
	output      logic [2:0] bus_action,
	output      logic [1:0] mode,
	output      logic [2:0] error_code,
	output      logic       tx_done,
	output      logic       tx_failed,
	output      logic [7:0] read_data,
	output      logic [5:0] rx_count
);

	// scalar state
	mode_t            mode_q;
	logic             stop_pend_q;
	logic [7:0]       addr_rw_q;
	logic [LEN_W-1:0] mpos_q, mlen_q, rpos_q, ypos_q, ylen_q;
	err_t             err_q;

	// next state
	mode_t            mode_n;
	logic             stop_pend_n;
	logic [7:0]       addr_rw_n;
	logic [LEN_W-1:0] mpos_n, mlen_n, rpos_n, ypos_n, ylen_n;
	err_t             err_n;

	// step results
	src_t             drv_src, rd_src;
	logic [7:0]       drv_const;
	logic             drv_vld, done, fail;
	act_t             act;
	logic [LEN_W-1:0] cnt;

	// RAM ports
	logic              m_we, m_re, r_we, r_re, y_we, y_re;
	logic [BUF_AW-1:0] m_wa, m_ra, r_wa, r_ra, y_wa, y_ra;
	logic [7:0]        m_wd, r_wd, y_wd, m_rd, r_rd, y_rd;

	// read stage
	logic             vld_s1;
	src_t             drv_src_s1, rd_src_s1;
	logic [7:0]       drv_const_s1;
	logic             drv_vld_s1, done_s1, fail_s1;
	act_t             act_s1;
	mode_t            mode_s1;
	err_t             err_s1;
	logic [LEN_W-1:0] cnt_s1;

	// output register
	logic             out_vld_q;
	logic [7:0]       drive_byte_q, read_data_q;
	logic             drive_valid_q, done_q, fail_q;
	act_t             act_q;
	mode_t            mode_q2;
	err_t             err_q2;
	logic [LEN_W-1:0] cnt_q;

	logic accept, adv_s1;
	logic [LEN_W-1:0] idx_ext, mpos_st;

	assign adv_s1   = vld_s1 && (!out_vld_q || !out_stall);
	assign in_stall = vld_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;
	assign idx_ext  = {1'b0, index};

	always_comb begin
		mode_n      = mode_q;
		stop_pend_n = stop_pend_q;
		addr_rw_n   = addr_rw_q;
		mpos_n      = mpos_q;
		mlen_n      = mlen_q;
		rpos_n      = rpos_q;
		ypos_n      = ypos_q;
		ylen_n      = ylen_q;
		err_n       = err_q;
		drv_src     = SRC_CONST;
		rd_src      = SRC_CONST;
		drv_const   = 8'h00;
		drv_vld     = 1'b0;
		done        = 1'b0;
		fail        = 1'b0;
		act         = ACT_NONE;
		cnt         = '0;
		m_we = 1'b0; m_re = 1'b0; r_we = 1'b0; r_re = 1'b0; y_we = 1'b0; y_re = 1'b0;
		m_wa = mpos_q[BUF_AW-1:0];
		m_ra = mpos_q[BUF_AW-1:0];
		r_wa = rpos_q[BUF_AW-1:0];
		r_ra = index[BUF_AW-1:0];
		y_wa = index[BUF_AW-1:0];
		y_ra = ypos_q[BUF_AW-1:0];
		m_wd = data_byte;
		r_wd = data_byte;
		y_wd = data_byte;
		mpos_st = mpos_q;

		// master receive store
		if ((cmd == CMD_MR_DATA_ACK || cmd == CMD_MR_DATA_NAK) && mpos_q < BUF_LIMIT) begin
			m_we    = 1'b1;
			mpos_st = mpos_q + 1'b1;
		end

		case (cmd)
			CMD_START_SENT: begin
				drv_const = addr_rw_q;
				drv_vld   = 1'b1;
				act       = ACT_ACK;
			end
			CMD_MT_ACK: begin
				if (mpos_q < mlen_q && mpos_q < BUF_LIMIT) begin
					m_re    = 1'b1;
					drv_src = SRC_MASTER;
					drv_vld = 1'b1;
					mpos_n  = mpos_q + 1'b1;
					act     = ACT_ACK;
				end else begin
					done        = (mode_q == MODE_MTX) && (mpos_q >= mlen_q);
					fail        = (mode_q == MODE_MTX) && (mpos_q < mlen_q);
					stop_pend_n = 1'b1;
					act         = ACT_STOP;
				end
			end
			CMD_MT_ADDR_NAK, CMD_MT_DATA_NAK, CMD_MR_ADDR_NAK, CMD_BUS_ERROR: begin
				done        = (mode_q == MODE_MTX) && (mpos_q >= mlen_q);
				fail        = (mode_q == MODE_MTX) && (mpos_q < mlen_q);
				stop_pend_n = 1'b1;
				act         = ACT_STOP;
				if (cmd == CMD_MT_ADDR_NAK) err_n = ERR_ADDR_NACK;
				if (cmd == CMD_MT_DATA_NAK) err_n = ERR_DATA_NACK;
				if (cmd == CMD_BUS_ERROR)   err_n = ERR_BUS;
			end
			CMD_ARB_LOST: begin
				err_n  = ERR_ARB_LOST;
				act    = ACT_RELEASE;
				mode_n = MODE_READY;
			end
			CMD_MR_DATA_ACK: begin
				mpos_n = mpos_st;
				act    = (mpos_st < mlen_q) ? ACT_ACK : ACT_NACK;
			end
			CMD_MR_ADDR_ACK: begin
				act = (mpos_q < mlen_q) ? ACT_ACK : ACT_NACK;
			end
			CMD_MR_DATA_NAK: begin
				mpos_n      = mpos_st;
				done        = (mode_q == MODE_MTX) && (mpos_st >= mlen_q);
				fail        = (mode_q == MODE_MTX) && (mpos_st < mlen_q);
				stop_pend_n = 1'b1;
				act         = ACT_STOP;
			end
			CMD_SR_ADDRESSED: begin
				mode_n = MODE_SRX;
				rpos_n = '0;
				act    = ACT_ACK;
			end
			CMD_SR_DATA_ACK: begin
				if (rpos_q < BUF_LIMIT) begin
					r_we   = 1'b1;
					rpos_n = rpos_q + 1'b1;
					act    = ACT_ACK;
				end else begin
					err_n = ERR_RECV_FULL;
					act   = ACT_NACK;
				end
			end
			CMD_SR_STOP: begin
				act    = ACT_RELEASE;
				mode_n = MODE_READY;
				r_we   = (rpos_q < BUF_LIMIT);
				r_wd   = 8'h00;
			end
			CMD_SR_DATA_NAK: begin
				act    = ACT_NACK;
				rpos_n = '0;
			end
			CMD_ST_ADDRESSED: begin
				mode_n  = MODE_STX;
				ypos_n  = LEN_W'(1);
				drv_vld = 1'b1;
				if (ylen_q == '0) begin
					// empty reply: send a single zero byte
					y_we   = 1'b1;
					y_wa   = '0;
					y_wd   = 8'h00;
					ylen_n = LEN_W'(1);
				end else begin
					y_re    = 1'b1;
					y_ra    = '0;
					drv_src = SRC_REPLY;
				end
				if (ylen_n > LEN_W'(1)) begin
					act = ACT_ACK;
				end else begin
					ylen_n = '0;
					act    = ACT_NACK;
				end
			end
			CMD_ST_DATA_ACK: begin
				drv_vld = 1'b1;
				if (ypos_q < BUF_LIMIT) begin
					y_re    = 1'b1;
					drv_src = SRC_REPLY;
					ypos_n  = ypos_q + 1'b1;
				end
				if (ypos_n < ylen_q) begin
					act = ACT_ACK;
				end else begin
					ylen_n = '0;
					act    = ACT_NACK;
				end
			end
			CMD_ST_DONE: begin
				act    = ACT_ACK;
				mode_n = MODE_READY;
			end
			CMD_STOP_DONE: begin
				if (stop_pend_q) begin
					if (mode_q == MODE_MTX) begin
						mpos_n = '0;
						mlen_n = '0;
					end
					mode_n      = MODE_READY;
					stop_pend_n = 1'b0;
				end
			end
			CMD_BEGIN: begin
				if (mode_q == MODE_READY) begin
					addr_rw_n = {target_address, read_not_write};
					mpos_n    = '0;
					mlen_n    = (length > BUF_LIMIT) ? BUF_LIMIT : length;
					mode_n    = MODE_MTX;
					act       = ACT_START;
				end
			end
			CMD_LOAD_MASTER: begin
				m_we = (idx_ext < BUF_LIMIT);
				m_wa = index[BUF_AW-1:0];
			end
			CMD_LOAD_REPLY: begin
				y_we   = (idx_ext < BUF_LIMIT);
				ylen_n = (length > BUF_LIMIT) ? BUF_LIMIT : length;
			end
			CMD_READ: begin
				if (idx_ext < BUF_LIMIT) begin
					if (read_not_write) begin
						m_re   = 1'b1;
						m_ra   = index[BUF_AW-1:0];
						rd_src = SRC_MASTER;
					end else begin
						r_re   = 1'b1;
						rd_src = SRC_RECV;
					end
				end
			end
			CMD_TAKE_FRAME: begin
				if (rpos_q != '0 && mode_q == MODE_READY) begin
					cnt    = rpos_q;
					rpos_n = '0;
				end
			end
			default: begin
			end
		endcase
	end

	i2cts_ram #(.DEPTH(BUF_BYTES), .WIDTH(8)) u_master_ram (
		.clk(clk), .we(accept && m_we), .waddr(m_wa), .wdata(m_wd),
		.re(accept && m_re), .raddr(m_ra), .rdata(m_rd)
	);

	i2cts_ram #(.DEPTH(BUF_BYTES), .WIDTH(8)) u_recv_ram (
		.clk(clk), .we(accept && r_we), .waddr(r_wa), .wdata(r_wd),
		.re(accept && r_re), .raddr(r_ra), .rdata(r_rd)
	);

	i2cts_ram #(.DEPTH(BUF_BYTES), .WIDTH(8)) u_reply_ram (
		.clk(clk), .we(accept && y_we), .waddr(y_wa), .wdata(y_wd),
		.re(accept && y_re), .raddr(y_ra), .rdata(y_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_READY;
			stop_pend_q <= 1'b0;
			addr_rw_q   <= 8'h00;
			mpos_q      <= '0;
			mlen_q      <= '0;
			rpos_q      <= '0;
			ypos_q      <= '0;
			ylen_q      <= '0;
			err_q       <= ERR_NONE;
		end else if (accept) begin
			mode_q      <= mode_n;
			stop_pend_q <= stop_pend_n;
			addr_rw_q   <= addr_rw_n;
			mpos_q      <= mpos_n;
			mlen_q      <= mlen_n;
			rpos_q      <= rpos_n;
			ypos_q      <= ypos_n;
			ylen_q      <= ylen_n;
			err_q       <= err_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			drv_src_s1   <= drv_src;
			rd_src_s1    <= rd_src;
			drv_const_s1 <= drv_const;
			drv_vld_s1   <= drv_vld;
			done_s1      <= done;
			fail_s1      <= fail;
			act_s1       <= act;
			mode_s1      <= mode_n;
			err_s1       <= err_n;
			cnt_s1       <= cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			case (drv_src_s1)
				SRC_MASTER: drive_byte_q <= m_rd;
				SRC_REPLY:  drive_byte_q <= y_rd;
				default:    drive_byte_q <= drv_const_s1;
			endcase
			case (rd_src_s1)
				SRC_MASTER: read_data_q <= m_rd;
				SRC_RECV:   read_data_q <= r_rd;
				default:    read_data_q <= 8'h00;
			endcase
			drive_valid_q <= drv_vld_s1;
			done_q        <= done_s1;
			fail_q        <= fail_s1;
			act_q         <= act_s1;
			mode_q2       <= mode_s1;
			err_q2        <= err_s1;
			cnt_q         <= cnt_s1;
		end
	end

	assign out_valid   = out_vld_q;
	assign drive_byte  = drive_byte_q;
	assign drive_valid = drive_valid_q;
	assign bus_action  = act_q;
	assign mode        = mode_q2;
	assign error_code  = err_q2;
	assign tx_done     = done_q;
	assign tx_failed   = fail_q;
	assign read_data   = read_data_q;
	assign rx_count    = cnt_q;

endmodule

`default_nettype wire

[hw/rtl/i2cts_ram.sv]
// Simple dual-port RAM, one write and one registered read port.
// Standalone; used for the three byte buffers of the sequencer.
`default_nettype none

module i2cts_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/i2cts_checker.sv]
// Port-level checks for the I2C transfer sequencer, bound to the top level.
// Depends on i2cts_pkg and i2c_master_slave_transfer_sequencer.
`default_nettype none

module i2cts_checker
	import i2cts_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] drive_byte,
	input wire logic       drive_valid,
	input wire logic [2:0] bus_action,
	input wire logic [1:0] mode,
	input wire logic       tx_done,
	input wire logic       tx_failed,
	input wire logic [5:0] rx_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(drive_byte))
		else $error("output word changed while stalled");

	a_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(tx_done && tx_failed))
		else $error("tx_done and tx_failed together");

	a_done_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (tx_done || tx_failed) |-> bus_action == ACT_STOP)
		else $error("transfer status without stop");

	a_drive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !drive_valid |-> drive_byte == 8'h00)
		else $error("drive byte set without drive valid");

	a_take_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rx_count != '0 |-> bus_action == ACT_NONE && mode == MODE_READY)
		else $error("frame taken outside ready mode");

endmodule

bind i2c_master_slave_transfer_sequencer i2cts_checker u_i2cts_checker (.*);

`default_nettype wire

[sim/tb_top.sv]
// Testbench for the I2C master/slave transfer sequencer: directed and random bus
// event traffic, each result word checked against an in-bench predictor.
// Depends on i2cts_pkg and i2c_master_slave_transfer_sequencer.
`timescale 1ns / 100ps

module tb_top;
	import i2cts_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 5'd23;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 5'd31;

	typedef struct {
		logic [4:0] op;
		logic [7:0] data;
		logic [4:0] idx;
		logic [5:0] len;
		logic [6:0] addr;
		logic       rnw;
	} word_t;

	typedef struct {
		logic [7:0] drv;
		logic       drv_ok;
		act_t       act;
		mode_t      md;
		err_t       err;
		logic       done;
		logic       failed;
		logic [7:0] rd;
		logic [5:0] cnt;
	} result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [4:0] cmd = '0;
	logic [7:0] data_byte = '0;
	logic [4:0] index = '0;
	logic [5:0] length = '0;
	logic [6:0] target_address = '0;
	logic       read_not_write = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] drive_byte;
	logic       drive_valid;
	logic [2:0] bus_action;
	logic [1:0] mode;
	logic [2:0] error_code;
	logic       tx_done;
	logic       tx_failed;
	logic [7:0] read_data;
	logic [5:0] rx_count;

	// predictor state
	mode_t      sq_mode = MODE_READY;
	logic       sq_stop_pend = 1'b0;
	logic [7:0] sq_addr_byte = '0;
	err_t       sq_err = ERR_NONE;
	logic [7:0] mst_buf [BUF_BYTES];
	logic [7:0] rcv_buf [BUF_BYTES];
	logic [7:0] rpl_buf [BUF_BYTES];
	bit         mst_set [BUF_BYTES];
	bit         rcv_set [BUF_BYTES];
	bit         rpl_set [BUF_BYTES];
	logic [5:0] mst_pos = '0, mst_len = '0, rcv_pos = '0, rpl_pos = '0, rpl_len = '0;

	result_t    pending_answers [$];
	result_t    head;
	int         mismatches = 0;
	int         words_sent = 0;
	int         results_checked = 0;
	int         stops_done = 0;
	int         stops_failed = 0;
	int         frames_full = 0;
	int         next_gap = 1;
	int         stall_left = 0;
	bit         quiet = 1'b0;

	i2c_master_slave_transfer_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.data_byte(data_byte),
		.index(index),
		.length(length),
		.target_address(target_address),
		.read_not_write(read_not_write),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.drive_byte(drive_byte),
		.drive_valid(drive_valid),
		.bus_action(bus_action),
		.mode(mode),
		.error_code(error_code),
		.tx_done(tx_done),
		.tx_failed(tx_failed),
		.read_data(read_data),
		.rx_count(rx_count)
	);

	always #5 clk = ~clk;

	function automatic logic [5:0] sat_len(logic [5:0] l);
		return (l > BUF_LIMIT) ? BUF_LIMIT : l;
	endfunction

	function automatic void halt_bus(inout result_t r);
		if (sq_mode == MODE_MTX) begin
			if (mst_pos >= mst_len) begin
				r.done = 1'b1;
				stops_done++;
			end else begin
				r.failed = 1'b1;
				stops_failed++;
			end
		end
		sq_stop_pend = 1'b1;
		r.act = ACT_STOP;
	endfunction

	function automatic void master_keep(logic [7:0] b);
		if (mst_pos < BUF_LIMIT) begin
			mst_buf[mst_pos[4:0]] = b;
			mst_set[mst_pos[4:0]] = 1'b1;
			mst_pos++;
		end
	endfunction

	function automatic void sequencer_step(input word_t w, output result_t r);
		r.drv = '0;
		r.drv_ok = 1'b0;
		r.act = ACT_NONE;
		r.done = 1'b0;
		r.failed = 1'b0;
		r.rd = '0;
		r.cnt = '0;
		case (w.op)
			CMD_START_SENT: begin
				r.drv = sq_addr_byte;
				r.drv_ok = 1'b1;
				r.act = ACT_ACK;
			end
			CMD_MT_ACK: begin
				if (mst_pos < mst_len && mst_pos < BUF_LIMIT) begin
					r.drv = mst_buf[mst_pos[4:0]];
					r.drv_ok = 1'b1;
					mst_pos++;
					r.act = ACT_ACK;
				end else begin
					halt_bus(r);
				end
			end
			CMD_MT_ADDR_NAK: begin
				sq_err = ERR_ADDR_NACK;
				halt_bus(r);
			end
			CMD_MT_DATA_NAK: begin
				sq_err = ERR_DATA_NACK;
				halt_bus(r);
			end
			CMD_ARB_LOST: begin
				sq_err = ERR_ARB_LOST;
				r.act = ACT_RELEASE;
				sq_mode = MODE_READY;
			end
			CMD_MR_DATA_ACK: begin
				master_keep(w.data);
				r.act = (mst_pos < mst_len) ? ACT_ACK : ACT_NACK;
			end
			CMD_MR_ADDR_ACK: begin
				r.act = (mst_pos < mst_len) ? ACT_ACK : ACT_NACK;
			end
			CMD_MR_DATA_NAK: begin
				master_keep(w.data);
				halt_bus(r);
			end
			CMD_MR_ADDR_NAK: begin
				halt_bus(r);
			end
			CMD_SR_ADDRESSED: begin
				sq_mode = MODE_SRX;
				rcv_pos = '0;
				r.act = ACT_ACK;
			end
			CMD_SR_DATA_ACK: begin
				if (rcv_pos < BUF_LIMIT) begin
					rcv_buf[rcv_pos[4:0]] = w.data;
					rcv_set[rcv_pos[4:0]] = 1'b1;
					rcv_pos++;
					r.act = ACT_ACK;
				end else begin
					sq_err = ERR_RECV_FULL;
					r.act = ACT_NACK;
					frames_full++;
				end
			end
			CMD_SR_STOP: begin
				r.act = ACT_RELEASE;
				sq_mode = MODE_READY;
				if (rcv_pos < BUF_LIMIT) begin
					rcv_buf[rcv_pos[4:0]] = 8'h00;
					rcv_set[rcv_pos[4:0]] = 1'b1;
				end
			end
			CMD_SR_DATA_NAK: begin
				r.act = ACT_NACK;
				rcv_pos = '0;
			end
			CMD_ST_ADDRESSED, CMD_ST_DATA_ACK: begin
				if (w.op == CMD_ST_ADDRESSED) begin
					sq_mode = MODE_STX;
					rpl_pos = '0;
					if (rpl_len == '0) begin
						rpl_len = 6'd1;
						rpl_buf[0] = 8'h00;
						rpl_set[0] = 1'b1;
					end
				end
				r.drv_ok = 1'b1;
				if (rpl_pos < BUF_LIMIT) begin
					r.drv = rpl_buf[rpl_pos[4:0]];
					rpl_pos++;
				end
				if (rpl_pos < rpl_len) begin
					r.act = ACT_ACK;
				end else begin
					rpl_len = '0;
					r.act = ACT_NACK;
				end
			end
			CMD_ST_DONE: begin
				r.act = ACT_ACK;
				sq_mode = MODE_READY;
			end
			CMD_BUS_ERROR: begin
				halt_bus(r);
				sq_err = ERR_BUS;
			end
			CMD_STOP_DONE: begin
				if (sq_stop_pend) begin
					if (sq_mode == MODE_MTX) begin
						mst_pos = '0;
						mst_len = '0;
					end
					sq_mode = MODE_READY;
					sq_stop_pend = 1'b0;
				end
			end
			CMD_BEGIN: begin
				if (sq_mode == MODE_READY) begin
					sq_addr_byte = {w.addr, w.rnw};
					mst_pos = '0;
					mst_len = sat_len(w.len);
					sq_mode = MODE_MTX;
					r.act = ACT_START;
				end
			end
			CMD_LOAD_MASTER: begin
				mst_buf[w.idx] = w.data;
				mst_set[w.idx] = 1'b1;
			end
			CMD_LOAD_REPLY: begin
				rpl_buf[w.idx] = w.data;
				rpl_set[w.idx] = 1'b1;
				rpl_len = sat_len(w.len);
			end
			CMD_READ: begin
				r.rd = w.rnw ? mst_buf[w.idx] : rcv_buf[w.idx];
			end
			CMD_TAKE_FRAME: begin
				if (rcv_pos > 0 && sq_mode == MODE_READY) begin
					r.cnt = rcv_pos;
					rcv_pos = '0;
				end
			end
			default: ;
		endcase
		r.md = sq_mode;
		r.err = sq_err;
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// result side: check each accepted word, then draw the stall before the next
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				$error("result word with no expectation waiting");
				mismatches++;
			end else begin
				head = pending_answers.pop_front();
				check_field("drive_byte", head.drv, drive_byte);
				check_field("drive_valid", 8'(head.drv_ok), 8'(drive_valid));
				check_field("bus_action", 8'(head.act), 8'(bus_action));
				check_field("mode", 8'(head.md), 8'(mode));
				check_field("error_code", 8'(head.err), 8'(error_code));
				check_field("tx_done", 8'(head.done), 8'(tx_done));
				check_field("tx_failed", 8'(head.failed), 8'(tx_failed));
				check_field("read_data", head.rd, read_data);
				check_field("rx_count", 8'(head.cnt), 8'(rx_count));
				results_checked++;
			end
			stall_left = quiet ? 0 : $urandom_range(0, 15);
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic word_t rnd_word(logic [4:0] op);
		word_t w;
		w.op = op;
		w.data = 8'($urandom);
		w.idx = 5'($urandom);
		w.len = 6'($urandom);
		w.addr = 7'($urandom);
		w.rnw = 1'($urandom);
		return w;
	endfunction

	function automatic int pick_len();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
	endfunction

	task automatic send_word(input word_t w);
		result_t r;
		if (next_gap > 0)
			repeat (next_gap) @(posedge clk);
		cmd <= w.op;
		data_byte <= w.data;
		index <= w.idx;
		length <= w.len;
		target_address <= w.addr;
		read_not_write <= w.rnw;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sequencer_step(w, r);
		pending_answers.push_back(r);
		words_sent++;
		next_gap = quiet ? 0 : $urandom_range(0, 15);
		if (next_gap > 0)
			in_valid <= 1'b0;
	endtask

	task automatic hold_input();
		if (next_gap == 0) begin
			in_valid <= 1'b0;
			next_gap = 1;
		end
	endtask

	// fills master or reply entries the word would read unwritten; an unwritten receive read goes to master
	task automatic issue_word(input word_t w);
		word_t fill;
		case (w.op)
			CMD_MT_ACK: begin
				if (mst_pos < mst_len && mst_pos < BUF_LIMIT && !mst_set[mst_pos[4:0]]) begin
					fill = rnd_word(CMD_LOAD_MASTER);
					fill.idx = mst_pos[4:0];
					send_word(fill);
				end
			end
			CMD_ST_ADDRESSED: begin
				if (rpl_len != '0 && !rpl_set[0]) begin
					fill = rnd_word(CMD_LOAD_REPLY);
					fill.idx = '0;
					fill.len = rpl_len;
					send_word(fill);
				end
			end
			CMD_ST_DATA_ACK: begin
				if (rpl_pos < BUF_LIMIT && !rpl_set[rpl_pos[4:0]]) begin
					fill = rnd_word(CMD_LOAD_REPLY);
					fill.idx = rpl_pos[4:0];
					fill.len = rpl_len;
					send_word(fill);
				end
			end
			CMD_READ: begin
				if (!w.rnw && !rcv_set[w.idx])
					w.rnw = 1'b1;
				if (w.rnw && !mst_set[w.idx]) begin
					fill = rnd_word(CMD_LOAD_MASTER);
					fill.idx = w.idx;
					send_word(fill);
				end
			end
			default: ;
		endcase
		send_word(w);
	endtask

	task automatic post(input logic [4:0] op);
		issue_word(rnd_word(op));
	endtask

	task automatic post_full(input logic [4:0] op, input logic [7:0] d, input logic [4:0] i,
			input logic [5:0] l, input logic [6:0] a, input logic rw);
		word_t w;
		w.op = op;
		w.data = d;
		w.idx = i;
		w.len = l;
		w.addr = a;
		w.rnw = rw;
		issue_word(w);
	endtask

	task automatic post_len(input logic [4:0] op, input int n, input logic rw);
		word_t w;
		w = rnd_word(op);
		w.len = 6'(n);
		w.rnw = rw;
		issue_word(w);
	endtask

	task automatic test_idle_events();
		post(CMD_START_SENT);
		post(CMD_TAKE_FRAME);
		post(CMD_STOP_DONE);
		post(CMD_UNUSED_LO);
		post(CMD_UNUSED_HI);
		post_full(CMD_READ, 8'h00, 5'd31, 6'd0, 7'h00, 1'b0);
	endtask

	task automatic test_master_transmit();
		post_full(CMD_LOAD_MASTER, 8'h00, 5'd0, 6'd0, 7'h00, 1'b0);
		post_full(CMD_LOAD_MASTER, 8'hFF, 5'd1, 6'd0, 7'h00, 1'b0);
		post_full(CMD_BEGIN, 8'h00, 5'd0, 6'd2, 7'h7F, 1'b0);
		post_full(CMD_BEGIN, 8'h00, 5'd0, 6'd5, 7'h12, 1'b1);
		post(CMD_START_SENT);
		repeat (3) post(CMD_MT_ACK);
		post(CMD_STOP_DONE);
		post_full(CMD_BEGIN, 8'h00, 5'd0, 6'd63, 7'h00, 1'b1);
		post(CMD_START_SENT);
		post(CMD_MT_ACK);
		post(CMD_MT_DATA_NAK);
		post(CMD_STOP_DONE);
	endtask

	task automatic test_master_receive();
		post_full(CMD_BEGIN, 8'h00, 5'd0, 6'd1, 7'h55, 1'b1);
		post(CMD_START_SENT);
		post(CMD_MR_ADDR_ACK);
		post_full(CMD_MR_DATA_NAK, 8'h5A, 5'd0, 6'd0, 7'h00, 1'b0);
		post(CMD_STOP_DONE);
		post_full(CMD_READ, 8'h00, 5'd0, 6'd0, 7'h00, 1'b1);
		post_full(CMD_BEGIN, 8'h00, 5'd0, 6'd0, 7'h2A, 1'b0);
		post(CMD_START_SENT);
		post(CMD_MR_ADDR_NAK);
		post(CMD_STOP_DONE);
		post(CMD_ARB_LOST);
		post(CMD_MT_ADDR_NAK);
		post(CMD_STOP_DONE);
	endtask

	task automatic test_slave_paths();
		post(CMD_SR_ADDRESSED);
		post_full(CMD_SR_DATA_ACK, 8'hFF, 5'd0, 6'd0, 7'h00, 1'b0);
		post(CMD_SR_DATA_NAK);
		post_full(CMD_SR_DATA_ACK, 8'h00, 5'd0, 6'd0, 7'h00, 1'b0);
		post(CMD_SR_STOP);
		post(CMD_TAKE_FRAME);
		post_full(CMD_READ, 8'h00, 5'd0, 6'd0, 7'h00, 1'b0);
		post(CMD_ST_ADDRESSED);
		post(CMD_ST_DONE);
		post_full(CMD_LOAD_REPLY, 8'h81, 5'd0, 6'd2, 7'h00, 1'b0);
		post_full(CMD_LOAD_REPLY, 8'h7E, 5'd1, 6'd2, 7'h00, 1'b0);
		post(CMD_ST_ADDRESSED);
		post(CMD_ST_DATA_ACK);
		post(CMD_ST_DONE);
		post(CMD_BUS_ERROR);
		post(CMD_STOP_DONE);
	endtask

	task automatic test_buffer_limits();
		post(CMD_SR_ADDRESSED);
		repeat (33) post(CMD_SR_DATA_ACK);
		post(CMD_SR_STOP);
		post(CMD_TAKE_FRAME);
		post_full(CMD_READ, 8'h00, 5'd31, 6'd0, 7'h00, 1'b0);
		post_full(CMD_BEGIN, 8'h00, 5'd0, 6'd32, 7'h01, 1'b1);
		repeat (33) post(CMD_MR_DATA_ACK);
		post(CMD_MR_DATA_NAK);
		post(CMD_STOP_DONE);
		post_full(CMD_LOAD_REPLY, 8'hC3, 5'd31, 6'd63, 7'h00, 1'b0);
		post(CMD_ST_ADDRESSED);
		repeat (32) post(CMD_ST_DATA_ACK);
		post(CMD_ST_DONE);
	endtask

	task automatic test_random_traffic();
		int goal;
		int n;
		int k;
		bit drained;
		goal = words_sent + 600;
		drained = 1'b0;
		while (words_sent < goal) begin
			quiet = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 4) != 0) begin
				if (sq_stop_pend)
					post(CMD_STOP_DONE);
				if (sq_mode != MODE_READY)
					post(CMD_ST_DONE);
			end
			n = pick_len();
			case ($urandom_range(0, 9))
				0, 1: begin
					repeat ($urandom_range(0, 3)) post(CMD_LOAD_MASTER);
					post_len(CMD_BEGIN, n, 1'b0);
					post(CMD_START_SENT);
					repeat ($urandom_range(0, (n > 33) ? 33 : n + 1)) post(CMD_MT_ACK);
					case ($urandom_range(0, 5))
						0: post(CMD_MT_DATA_NAK);
						1: post(CMD_MT_ADDR_NAK);
						2: post(CMD_ARB_LOST);
						3: post(CMD_BUS_ERROR);
						default: post(CMD_MT_ACK);
					endcase
					post(CMD_STOP_DONE);
				end
				2, 3: begin
					post_len(CMD_BEGIN, n, 1'b1);
					post(CMD_START_SENT);
					if ($urandom_range(0, 4) == 0) begin
						post(CMD_MR_ADDR_NAK);
					end else begin
						post(CMD_MR_ADDR_ACK);
						repeat ($urandom_range(0, (n > 34) ? 34 : n)) post(CMD_MR_DATA_ACK);
						post(CMD_MR_DATA_NAK);
					end
					post(CMD_STOP_DONE);
					if ($urandom_range(0, 1) == 0)
						post_full(CMD_READ, 8'h00, 5'($urandom), 6'd0, 7'h00, 1'b1);
				end
				4, 5: begin
					k = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 5);
					post(CMD_SR_ADDRESSED);
					repeat (k) post(CMD_SR_DATA_ACK);
					if ($urandom_range(0, 5) == 0)
						post(CMD_SR_DATA_NAK);
					post(CMD_SR_STOP);
					if ($urandom_range(0, 3) != 0)
						post(CMD_TAKE_FRAME);
					post_full(CMD_READ, 8'h00, 5'($urandom_range(0, k)), 6'd0, 7'h00, 1'b0);
				end
				6, 7: begin
					k = $urandom_range(0, 3);
					repeat (k) post_len(CMD_LOAD_REPLY, pick_len(), 1'b0);
					post(CMD_ST_ADDRESSED);
					repeat ($urandom_range(0, (n > 34) ? 34 : n)) post(CMD_ST_DATA_ACK);
					post(CMD_ST_DONE);
				end
				8: begin
					post(CMD_LOAD_MASTER);
					post(CMD_LOAD_REPLY);
					post(CMD_READ);
					post(CMD_TAKE_FRAME);
				end
				default: begin
					repeat ($urandom_range(1, 4)) post(5'($urandom_range(0, 31)));
				end
			endcase
			if (!drained && words_sent > goal - 300) begin
				hold_input();
				while (pending_answers.size() != 0) @(posedge clk);
				drained = 1'b1;
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		int guard;
		foreach (mst_set[i]) begin
			mst_set[i] = 1'b0;
			rcv_set[i] = 1'b0;
			rpl_set[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_events();
		test_master_transmit();
		test_master_receive();
		test_slave_paths();
		test_buffer_limits();
		test_random_traffic();
		hold_input();
		guard = 0;
		while (pending_answers.size() != 0 && guard < 4000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (pending_answers.size() != 0) begin
			$error("%0d expected results never arrived", pending_answers.size());
			mismatches++;
		end
		$display("Sent %0d words, checked %0d results: %0d clean and %0d aborted master stops,",
			words_sent, results_checked, stops_done, stops_failed);
		$display("%0d receive-full nacks, buffer limits and random event noise included.",
			frames_full);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
